// ----- rtl/scrolling_bar_graph_store_unit_defines.svh -----
// ----------------------------------------------------------------------------
// scrolling bar graph store - assertion macros
// shared macros for the concurrent checks on the store's ports
// ----------------------------------------------------------------------------
`ifndef SCROLLING_BAR_GRAPH_STORE_UNIT_DEFINES_SVH
`define SCROLLING_BAR_GRAPH_STORE_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SBG_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scrolling bar graph store: check failed");

// consequent checked in the cycle after the antecedent
`define SBG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scrolling bar graph store: check failed");

`endif

// ----- rtl/sbg_pkg.sv -----
// ----------------------------------------------------------------------------
// sbg_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbg_pkg;

   // word field widths
   localparam int unsigned SampleW = 16;
   localparam int unsigned HeightW = 8;
   localparam int unsigned PixelW  = 8;
   localparam int unsigned BandW   = 2;
   localparam int unsigned ColumnW = 7;
   localparam int unsigned ProdW   = SampleW + HeightW;
   localparam int unsigned StepW   = 3;

   // configuration port
   localparam int unsigned CsrIndexW = 2;
   localparam int unsigned CsrDataW  = 16;

   localparam logic [CsrIndexW-1:0] CSR_FLOOR  = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_SPAN   = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [SampleW-1:0] FLOOR_RESET  = 16'd560;
   localparam logic [SampleW-1:0] SPAN_RESET   = 16'd130;
   localparam logic [HeightW-1:0] HEIGHT_RESET = 8'd24;

   // opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   // bands, top first
   localparam logic [BandW-1:0] BAND_TOP    = 2'd0;
   localparam logic [BandW-1:0] BAND_MIDDLE = 2'd1;
   localparam logic [BandW-1:0] BAND_BOTTOM = 2'd2;

   localparam logic [HeightW-1:0] MAX_HEIGHT = 8'hFF;

   typedef struct packed {
      logic capture;      // latch request word
      logic mul_load;     // register scaled product
      logic div_init;     // saturation / zero span check, seed divider
      logic div_step;     // one restoring divide step
      logic reduce_step;  // fold read index back into the ring
      logic ring_write;   // store height, advance pointer
      logic ring_read;    // read stored height
      logic out_load;     // load output register
   } cmd_type;

   typedef struct packed {
      logic div_skip;     // quotient already known after div_init
      logic div_last;     // current divide step is the last one
      logic reduce_more;  // read index still beyond the ring
      logic out_free;     // output register can take a word this cycle
   } status_type;

endpackage

// ----- rtl/sbg_ram.sv -----
// ----------------------------------------------------------------------------
// sbg_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbg_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sbg_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbg_ctrl
// sequencer for push (scale, divide, store) and read (index, fetch) words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_opcode,
   output logic                req_stall,
   output sbg_pkg::cmd_type    cmd,
   input  sbg_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_WRITE,
      ST_REDUCE,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   always_comb begin
      state_in = state_ff;
      stall_in = stall_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               stall_in    = 1'b1;
               state_in    = (req_opcode == sbg_pkg::OP_READ) ? ST_REDUCE : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = status.div_skip ? ST_WRITE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.ring_write = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_REDUCE: begin
            if (status.reduce_more) begin
               cmd.reduce_step = 1'b1;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.ring_read = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               stall_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            stall_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

endmodule

// ----- rtl/sbg_datapath.sv -----
// ----------------------------------------------------------------------------
// sbg_datapath
// config registers, scaler with bit-serial divider, ring and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbg_datapath #(
   parameter int unsigned RING_DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sbg_pkg::cmd_type                    cmd,
   output sbg_pkg::status_type                 status,
   input  logic                                req_opcode,
   input  logic [sbg_pkg::SampleW-1:0]         req_sample,
   input  logic [sbg_pkg::BandW-1:0]           req_band,
   input  logic [sbg_pkg::ColumnW-1:0]         req_column,
   input  logic                                csr_write,
   input  logic [sbg_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [sbg_pkg::CsrDataW-1:0]        csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sbg_pkg::HeightW-1:0]         rsp_height,
   output logic [sbg_pkg::PixelW-1:0]          rsp_pixel_byte
);

   localparam int unsigned PtrW  = $clog2(RING_DEPTH);
   localparam int unsigned FillW = $clog2(RING_DEPTH + 1);
   localparam int unsigned SumW  = $clog2(RING_DEPTH + (1 << sbg_pkg::ColumnW));
   localparam int unsigned SW    = sbg_pkg::SampleW;
   localparam int unsigned HW    = sbg_pkg::HeightW;
   localparam int unsigned PW    = sbg_pkg::ProdW;

   // lit pixels of one band, packed from the top bit
   function automatic logic [sbg_pkg::PixelW-1:0] band_pixels(
      input logic [HW-1:0]               h,
      input logic [sbg_pkg::BandW-1:0]   band
   );
      logic [HW-1:0] offset;
      logic [HW-1:0] lit;
      logic          known;
      offset = '0;
      known  = 1'b1;
      unique case (band)
         sbg_pkg::BAND_TOP:    offset = 8'd16;
         sbg_pkg::BAND_MIDDLE: offset = 8'd8;
         sbg_pkg::BAND_BOTTOM: offset = 8'd0;
         default:              known  = 1'b0;
      endcase
      lit = (h > offset) ? h - offset : '0;
      if (lit > 8'd8) begin
         lit = 8'd8;
      end
      return known ? ~(8'hFF >> lit) : '0;
   endfunction

   // configuration
   logic [SW-1:0] floor_ff, span_ff;
   logic [HW-1:0] hpix_ff;

   // push path
   logic [SW-1:0]             diff_ff;
   logic [PW-1:0]             prod_ff;
   logic [SW-1:0]             rem_ff;
   logic [HW-1:0]             low_ff;
   logic [HW-1:0]             quot_ff;
   logic [sbg_pkg::StepW-1:0] count_ff;

   // read path and ring control
   logic                      op_ff;
   logic [sbg_pkg::BandW-1:0] band_ff;
   logic [SumW-1:0]           sum_ff;
   logic                      hit_ff;
   logic [PtrW-1:0]           wp_ff, wp_in;
   logic [FillW-1:0]          fill_ff;

   // output register
   logic                      out_valid_ff;
   logic [HW-1:0]             out_height_ff;
   logic [sbg_pkg::PixelW-1:0] out_pixel_ff;

   logic [SW-1:0]   prod_hi;
   logic [SW:0]     trial;
   logic            trial_ge;
   logic [PtrW-1:0] rd_idx;
   logic            ring_full;
   logic            rd_hit;
   logic [HW-1:0]   rd_data;
   logic [HW-1:0]   read_height;

   assign prod_hi   = prod_ff[PW-1:HW];
   assign trial     = {rem_ff, low_ff[HW-1]};
   assign trial_ge  = trial >= {1'b0, span_ff};
   assign wp_in     = (wp_ff == PtrW'(RING_DEPTH - 1)) ? '0 : wp_ff + PtrW'(1);
   assign rd_idx    = sum_ff[PtrW-1:0];
   assign ring_full = fill_ff == FillW'(RING_DEPTH);
   // pushes fill entries 1, 2, ... in order, entry 0 last
   assign rd_hit    = ring_full || ((rd_idx != '0) && (FillW'(rd_idx) <= fill_ff));
   assign read_height = hit_ff ? rd_data : '0;

   assign status.div_skip    = (span_ff == '0) || (prod_hi >= span_ff);
   assign status.div_last    = count_ff == '1;
   assign status.reduce_more = sum_ff >= SumW'(RING_DEPTH);
   assign status.out_free    = !out_valid_ff || !rsp_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= sbg_pkg::FLOOR_RESET;
         span_ff  <= sbg_pkg::SPAN_RESET;
         hpix_ff  <= sbg_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            sbg_pkg::CSR_FLOOR:  floor_ff <= csr_data;
            sbg_pkg::CSR_SPAN:   span_ff  <= csr_data;
            sbg_pkg::CSR_HEIGHT: hpix_ff  <= csr_data[HW-1:0];
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         band_ff <= req_band;
         diff_ff <= (req_sample >= floor_ff) ? req_sample - floor_ff : '0;
         sum_ff  <= SumW'(wp_ff) + SumW'(1) + SumW'(req_column);
      end
      if (cmd.mul_load) begin
         prod_ff <= PW'(diff_ff) * PW'(hpix_ff);
      end
      if (cmd.div_init) begin
         rem_ff   <= prod_hi;
         low_ff   <= prod_ff[HW-1:0];
         count_ff <= '0;
         if (span_ff == '0) begin
            quot_ff <= '0;
         end else if (prod_hi >= span_ff) begin
            quot_ff <= sbg_pkg::MAX_HEIGHT;
         end else begin
            quot_ff <= '0;
         end
      end
      if (cmd.div_step) begin
         rem_ff   <= trial_ge ? SW'(trial - {1'b0, span_ff}) : trial[SW-1:0];
         low_ff   <= {low_ff[HW-2:0], 1'b0};
         quot_ff  <= {quot_ff[HW-2:0], trial_ge};
         count_ff <= count_ff + sbg_pkg::StepW'(1);
      end
      if (cmd.reduce_step) begin
         sum_ff <= sum_ff - SumW'(RING_DEPTH);
      end
      if (cmd.ring_read) begin
         hit_ff <= rd_hit;
      end
      if (cmd.out_load) begin
         if (op_ff == sbg_pkg::OP_READ) begin
            out_height_ff <= read_height;
            out_pixel_ff  <= band_pixels(read_height, band_ff);
         end else begin
            out_height_ff <= quot_ff;
            out_pixel_ff  <= '0;
         end
      end
   end

   // ring pointer, fill count and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.ring_write) begin
            wp_ff <= wp_in;
            if (!ring_full) begin
               fill_ff <= fill_ff + FillW'(1);
            end
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   sbg_ram #(
      .WIDTH (HW),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.ring_write),
      .wr_addr (wp_in),
      .wr_data (quot_ff),
      .rd_en   (cmd.ring_read),
      .rd_addr (rd_idx),
      .rd_data (rd_data)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_height     = out_height_ff;
   assign rsp_pixel_byte = out_pixel_ff;

endmodule

// ----- rtl/scrolling_bar_graph_store_unit.sv -----
// ----------------------------------------------------------------------------
// scrolling_bar_graph_store_unit
// ring of scaled bar heights for a scrolling graph, with band byte readout
// ----------------------------------------------------------------------------
//
//  channel   ports                       direction   one word
//  -------   -------------------------   ---------   -------------------------
//  req       req_valid / req_stall       in          opcode, sample, band, column
//  rsp       rsp_valid / rsp_stall       out         height, pixel_byte
//  csr       csr_write                   in          csr_index, csr_data
//
//  push: the restoring divider runs its 8 steps, one quotient bit a cycle,
//  and is skipped when the quotient is settled at once (zero span or
//  saturated height)
//  read: k ring-depth subtractions fold the column index back into the
//  ring before the fetch (k is 0 or 1 at the default depth)
//  one word in flight; a new word is taken once the previous result sits in
//  the output register, even while rsp_stall holds it
//  synchronous reset clears pointer, fill count and control, no clearing pass
//
`timescale 1ns / 1ps

module scrolling_bar_graph_store_unit #(
   parameter int unsigned RING_DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   // request words
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [sbg_pkg::SampleW-1:0]         req_sample,
   input  logic [sbg_pkg::BandW-1:0]           req_band,
   input  logic [sbg_pkg::ColumnW-1:0]         req_column,
   // result words
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sbg_pkg::HeightW-1:0]         rsp_height,
   output logic [sbg_pkg::PixelW-1:0]          rsp_pixel_byte,
   // configuration writes
   input  logic                                csr_write,
   input  logic [sbg_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [sbg_pkg::CsrDataW-1:0]        csr_data
);

   sbg_pkg::cmd_type    cmd;
   sbg_pkg::status_type status;

   // sequencer: accept, scale/divide or index fold, ring access, hand off
   sbg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .status     (status)
   );

   // datapath: config, multiplier, divider, ring memory, output register
   sbg_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_opcode),
      .req_sample     (req_sample),
      .req_band       (req_band),
      .req_column     (req_column),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_height     (rsp_height),
      .rsp_pixel_byte (rsp_pixel_byte)
   );

endmodule

// ----- rtl/sbg_checker.sv -----
// ----------------------------------------------------------------------------
// sbg_checker
// port level checks on the scrolling bar graph store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scrolling_bar_graph_store_unit_defines.svh"

module sbg_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sbg_pkg::HeightW-1:0]  rsp_height,
   input logic [sbg_pkg::PixelW-1:0]   rsp_pixel_byte
);

   // a held result word keeps its payload
   `SBG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_height) && $stable(rsp_pixel_byte))

   // one word in flight: the block is busy right after an accept
   `SBG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // no result is produced in the cycle right after an accept
   `SBG_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))

   // band byte is always a run of lit pixels from the top bit
   `SBG_ASSERT_SAME(a_pixel_run, clock, reset, rsp_valid, ((~rsp_pixel_byte) & 8'((~rsp_pixel_byte) + 8'd1)) == 8'd0)

endmodule

bind scrolling_bar_graph_store_unit sbg_checker u_sbg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_height     (rsp_height),
   .rsp_pixel_byte (rsp_pixel_byte)
);

// ----- dv/scrolling_bar_graph_store_unit_tb.sv -----
// ----------------------------------------------------------------------------
// scrolling_bar_graph_store_unit_tb
// self-checking bench: directed rows, then random pushes and band reads
// under several floor/span/height settings, with idle gaps and output stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scrolling_bar_graph_store_unit_tb;

   // band code with no pixels, register index with no register behind it
   localparam logic [sbg_pkg::BandW-1:0]     BAND_UNUSED = 2'd3;
   localparam logic [sbg_pkg::CsrIndexW-1:0] CSR_NONE    = 2'd3;

   localparam int RING_SLOTS   = 128;
   localparam int BATCH_WORDS  = 64;
   localparam int NUM_SETTINGS = 6;
   localparam int DRAIN_SLACK  = 16;

   // one result word
   typedef struct packed {
      logic [sbg_pkg::HeightW-1:0] height;
      logic [sbg_pkg::PixelW-1:0]  pixels;
   } bar_word_type;

   // one directed row: request fields, and the result where it is obvious
   typedef struct packed {
      logic                        op;
      logic [sbg_pkg::SampleW-1:0] sample;
      logic [sbg_pkg::BandW-1:0]   band;
      logic [sbg_pkg::ColumnW-1:0] column;
      logic                        typed;
      bar_word_type                result;
   } directed_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_opcode = sbg_pkg::OP_PUSH;
   logic [sbg_pkg::SampleW-1:0]   req_sample = '0;
   logic [sbg_pkg::BandW-1:0]     req_band = '0;
   logic [sbg_pkg::ColumnW-1:0]   req_column = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [sbg_pkg::HeightW-1:0]   rsp_height;
   logic [sbg_pkg::PixelW-1:0]    rsp_pixel_byte;
   logic                          csr_write = 1'b0;
   logic [sbg_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [sbg_pkg::CsrDataW-1:0]  csr_data = '0;

   // predictor state: its own copy of the ring and the registers
   logic [sbg_pkg::HeightW-1:0] ring_copy [RING_SLOTS];
   logic [sbg_pkg::ColumnW-1:0] newest_slot;
   logic [sbg_pkg::SampleW-1:0] floor_reg;
   logic [sbg_pkg::SampleW-1:0] span_reg;
   logic [sbg_pkg::HeightW-1:0] hpix_reg;

   // words predicted but not yet seen on the result side
   bar_word_type pending_q [$];
   bar_word_type oldest_word;

   // idle percentages for the two sides, changed per phase
   int send_idle_pct = 0;
   int stall_pct     = 0;

   int mismatch_count = 0;
   int push_count = 0, read_count = 0, sat_count = 0, zero_count = 0;
   int unused_band_count = 0, result_count = 0;

   directed_row_type dir_rows [23];

   scrolling_bar_graph_store_unit #(.RING_DEPTH(RING_SLOTS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_sample     (req_sample),
      .req_band       (req_band),
      .req_column     (req_column),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_height     (rsp_height),
      .rsp_pixel_byte (rsp_pixel_byte),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // lit pixels of one band, packed from bit 7 down
   function automatic logic [sbg_pkg::PixelW-1:0] band_pixels(
      input logic [sbg_pkg::HeightW-1:0] h,
      input logic [sbg_pkg::BandW-1:0]   bnd
   );
      int offset;
      int lit;
      if (bnd == BAND_UNUSED) return '0;
      offset = 16 - 8 * int'(bnd);
      lit = (int'(h) > offset) ? int'(h) - offset : 0;
      if (lit > 8) lit = 8;
      return 8'(16'h00FF << (8 - lit));
   endfunction

   // scale and store on a push, look up the column on a read
   function automatic bar_word_type predict_bar_word(
      input logic                        op,
      input logic [sbg_pkg::SampleW-1:0] smp,
      input logic [sbg_pkg::BandW-1:0]   bnd,
      input logic [sbg_pkg::ColumnW-1:0] col
   );
      bar_word_type                w;
      logic [sbg_pkg::SampleW-1:0] above;
      logic [sbg_pkg::ProdW-1:0]   prod;
      logic [sbg_pkg::ProdW-1:0]   quo;
      logic [sbg_pkg::ColumnW-1:0] slot;
      w = '0;
      if (op == sbg_pkg::OP_PUSH) begin
         // below the floor draws as zero
         above = (smp >= floor_reg) ? smp - floor_reg : '0;
         prod  = sbg_pkg::ProdW'(above) * sbg_pkg::ProdW'(hpix_reg);
         if (span_reg == '0) begin
            w.height = '0;
         end else begin
            quo = prod / sbg_pkg::ProdW'(span_reg);
            w.height = (quo > sbg_pkg::ProdW'(sbg_pkg::MAX_HEIGHT)) ?
                       sbg_pkg::MAX_HEIGHT : quo[sbg_pkg::HeightW-1:0];
         end
         // pointer moves first, then the height lands on the new slot
         newest_slot = newest_slot + 7'd1;
         ring_copy[newest_slot] = w.height;
      end else begin
         // column 0 is the slot just after the newest one
         slot = newest_slot + 7'd1 + col;
         w.height = ring_copy[slot];
         w.pixels = band_pixels(w.height, bnd);
      end
      return w;
   endfunction

   // all driving tasks start and end at a falling edge
   task automatic send_word(input logic op, input logic [sbg_pkg::SampleW-1:0] smp,
                            input logic [sbg_pkg::BandW-1:0] bnd,
                            input logic [sbg_pkg::ColumnW-1:0] col,
                            input logic typed, input bar_word_type typed_word);
      bar_word_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_sample <= smp;
      req_band   <= bnd;
      req_column <= col;
      do @(posedge clock); while (req_stall);
      predicted = predict_bar_word(op, smp, bnd, col);
      if (op == sbg_pkg::OP_PUSH) begin
         push_count++;
         if (predicted.height == sbg_pkg::MAX_HEIGHT) sat_count++;
         if (predicted.height == '0) zero_count++;
      end else begin
         read_count++;
         if (bnd == BAND_UNUSED) unused_band_count++;
      end
      // expectation goes in at the falling edge, away from the checker's edge
      @(negedge clock);
      pending_q.push_back(typed ? typed_word : predicted);
   endtask

   // stop sending and let every outstanding word come back
   task automatic drain_words();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [sbg_pkg::CsrIndexW-1:0] idx,
                            input logic [sbg_pkg::CsrDataW-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         sbg_pkg::CSR_FLOOR:  floor_reg = val;
         sbg_pkg::CSR_SPAN:   span_reg  = val;
         sbg_pkg::CSR_HEIGHT: hpix_reg  = val[sbg_pkg::HeightW-1:0];   // upper bits dropped
         default: ;                                                    // no register here
      endcase
      @(negedge clock);
   endtask

   task automatic random_batch(input int count);
      logic op;
      int   smp;
      for (int i = 0; i < count; i++) begin
         // now and then the sender holds off until the store is empty
         if ($urandom_range(0, 49) == 0) drain_words();
         op = 1'($urandom_range(0, 1));
         // mostly samples around the floor..floor+span window, some anywhere
         if ($urandom_range(0, 2) == 0) begin
            smp = $urandom_range(0, 65535);
         end else begin
            smp = int'(floor_reg) - 16 + int'($urandom_range(0, int'(span_reg) + 32));
         end
         if (smp < 0) smp = 0;
         if (smp > 65535) smp = 65535;
         send_word(op, sbg_pkg::SampleW'(smp), sbg_pkg::BandW'($urandom_range(0, 3)),
                   sbg_pkg::ColumnW'($urandom_range(0, 127)), 1'b0, '0);
      end
   endtask

   // result checker: every accepted word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (pending_q.size() == 0) begin
            $error("unexpected result word: height %0d pixel_byte %02h",
                   rsp_height, rsp_pixel_byte);
            mismatch_count++;
         end else begin
            oldest_word = pending_q.pop_front();
            if (rsp_height !== oldest_word.height) begin
               $error("height: expected %0d, got %0d", oldest_word.height, rsp_height);
               mismatch_count++;
            end
            if (rsp_pixel_byte !== oldest_word.pixels) begin
               $error("pixel_byte: expected %02h, got %02h",
                      oldest_word.pixels, rsp_pixel_byte);
               mismatch_count++;
            end
         end
      end
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      // reset state of the predictor
      for (int i = 0; i < RING_SLOTS; i++) ring_copy[i] = '0;
      newest_slot = '0;
      floor_reg   = sbg_pkg::FLOOR_RESET;
      span_reg    = sbg_pkg::SPAN_RESET;
      hpix_reg    = sbg_pkg::HEIGHT_RESET;

      // directed rows at the reset setting: floor 560, span 130, 24 pixels
      dir_rows = '{
         // empty ring reads back zero on the top and bottom bands and the unused band
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_TOP,    7'd0,   1'b1, '{8'd0,   8'h00}},
         '{sbg_pkg::OP_READ, 16'hFFFF, sbg_pkg::BAND_BOTTOM, 7'd127, 1'b1, '{8'd0,   8'h00}},
         '{sbg_pkg::OP_READ, 16'd0,    BAND_UNUSED,          7'd64,  1'b1, '{8'd0,   8'h00}},
         // below, at and above the floor, then saturation
         '{sbg_pkg::OP_PUSH, 16'd0,    sbg_pkg::BAND_TOP,    7'd0,   1'b1, '{8'd0,   8'h00}},
         '{sbg_pkg::OP_PUSH, 16'd559,  BAND_UNUSED,          7'd127, 1'b1, '{8'd0,   8'h00}},
         '{sbg_pkg::OP_PUSH, 16'd560,  sbg_pkg::BAND_MIDDLE, 7'd0,   1'b1, '{8'd0,   8'h00}},
         '{sbg_pkg::OP_PUSH, 16'd690,  sbg_pkg::BAND_TOP,    7'd0,   1'b1, '{8'd24,  8'h00}},
         '{sbg_pkg::OP_PUSH, 16'hFFFF, sbg_pkg::BAND_TOP,    7'd0,   1'b1, '{8'd255, 8'h00}},
         '{sbg_pkg::OP_PUSH, 16'd625,  sbg_pkg::BAND_TOP,    7'd0,   1'b1, '{8'd12,  8'h00}},
         '{sbg_pkg::OP_PUSH, 16'hAAAA, sbg_pkg::BAND_TOP,    7'd0,   1'b1, '{8'd255, 8'h00}},
         '{sbg_pkg::OP_PUSH, 16'h5555, sbg_pkg::BAND_TOP,    7'd0,   1'b1, '{8'd255, 8'h00}},
         // full height column: every band lit, unused band dark
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_TOP,    7'd123, 1'b1, '{8'd24,  8'hFF}},
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_MIDDLE, 7'd123, 1'b1, '{8'd24,  8'hFF}},
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_BOTTOM, 7'd123, 1'b1, '{8'd24,  8'hFF}},
         '{sbg_pkg::OP_READ, 16'd0,    BAND_UNUSED,          7'd123, 1'b1, '{8'd24,  8'h00}},
         // half height column: top dark, middle partly lit, bottom full
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_TOP,    7'd125, 1'b1, '{8'd12,  8'h00}},
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_MIDDLE, 7'd125, 1'b1, '{8'd12,  8'hF0}},
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_BOTTOM, 7'd125, 1'b1, '{8'd12,  8'hFF}},
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_TOP,    7'd127, 1'b1, '{8'd255, 8'hFF}},
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_MIDDLE, 7'd0,   1'b1, '{8'd0,   8'h00}},
         // the rest goes through the predictor
         '{sbg_pkg::OP_PUSH, 16'd600,  sbg_pkg::BAND_TOP,    7'd0,   1'b0, '{8'd0,   8'h00}},
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_BOTTOM, 7'd127, 1'b0, '{8'd0,   8'h00}},
         '{sbg_pkg::OP_READ, 16'd0,    sbg_pkg::BAND_TOP,    7'd124, 1'b0, '{8'd0,   8'h00}}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < $size(dir_rows); r++) begin
         send_word(dir_rows[r].op, dir_rows[r].sample, dir_rows[r].band,
                   dir_rows[r].column, dir_rows[r].typed, dir_rows[r].result);
      end
      drain_words();

      for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
         // receiver-heavy idling, then sender-heavy, then none
         if (ph < 2) begin
            send_idle_pct = 29;
            stall_pct     = 45;
         end else if (ph < 4) begin
            send_idle_pct = 45;
            stall_pct     = 29;
         end else begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end

         // register writes only with nothing in flight
         case (ph)
            0: ;   // stay at the reset setting
            1: begin
               // widest span, tallest graph, no floor
               write_reg(sbg_pkg::CSR_FLOOR, 16'd0);
               write_reg(sbg_pkg::CSR_SPAN, 16'hFFFF);
               write_reg(sbg_pkg::CSR_HEIGHT, 16'h00FF);
            end
            2: begin
               // zero span and zero height, floor at the top; stray index ignored
               write_reg(sbg_pkg::CSR_FLOOR, 16'hFFFF);
               write_reg(sbg_pkg::CSR_SPAN, 16'd0);
               write_reg(sbg_pkg::CSR_HEIGHT, 16'h0000);
               write_reg(CSR_NONE, 16'hFFFF);
            end
            3: begin
               // unit span: height follows the sample directly, saturates fast
               write_reg(sbg_pkg::CSR_FLOOR, 16'd0);
               write_reg(sbg_pkg::CSR_SPAN, 16'd1);
               write_reg(sbg_pkg::CSR_HEIGHT, 16'h0001);
            end
            4: begin
               write_reg(sbg_pkg::CSR_FLOOR, sbg_pkg::CsrDataW'($urandom_range(0, 65535)));
               write_reg(sbg_pkg::CSR_SPAN, sbg_pkg::CsrDataW'($urandom_range(0, 65535)));
               write_reg(sbg_pkg::CSR_HEIGHT, sbg_pkg::CsrDataW'($urandom_range(0, 65535)));
               write_reg(CSR_NONE, sbg_pkg::CsrDataW'($urandom_range(0, 65535)));
            end
            default: begin
               // graph-sized setting, junk in the upper height bits
               write_reg(sbg_pkg::CSR_FLOOR, sbg_pkg::CsrDataW'($urandom_range(0, 2000)));
               write_reg(sbg_pkg::CSR_SPAN, sbg_pkg::CsrDataW'($urandom_range(1, 500)));
               write_reg(sbg_pkg::CSR_HEIGHT,
                         16'hFF00 | sbg_pkg::CsrDataW'($urandom_range(8, 40)));
            end
         endcase
         csr_write <= 1'b0;

         random_batch(BATCH_WORDS);
         drain_words();
      end

      $display("covered %0d pushes (%0d saturated, %0d zero height) and %0d band reads",
               push_count, sat_count, zero_count, read_count);
      $display("%0d reads on the unused band, %0d result words, %0d register settings",
               unused_band_count, result_count, NUM_SETTINGS);
      if (mismatch_count == 0 && pending_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sbg_pkg.sv
rtl/sbg_ram.sv
rtl/sbg_ctrl.sv
rtl/sbg_datapath.sv
rtl/scrolling_bar_graph_store_unit.sv
rtl/sbg_checker.sv
dv/scrolling_bar_graph_store_unit_tb.sv
